// ===== rtl/stable_insertion_sorter_macros.svh =====
// Assertion macros shared by the stable insertion sorter modules.
`ifndef STABLE_INSERTION_SORTER_MACROS_SVH
`define STABLE_INSERTION_SORTER_MACROS_SVH

`ifndef SYNTHESIS
`define SIS_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("stable_insertion_sorter: assertion failed");
`define SIS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("stable_insertion_sorter: assertion failed");
`else
`define SIS_ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define SIS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/sis_pkg.sv =====
// Types and constants shared by the stable insertion sorter.
`timescale 1ns / 1ps
package sis_pkg;

  localparam int KEY_W  = 32;
  localparam int TAG_W  = 8;
  localparam int RANK_W = 4;

  typedef struct packed {
    logic [KEY_W-1:0] time_key;
    logic [TAG_W-1:0] entry_tag;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  sorted_key;
    logic [TAG_W-1:0]  sorted_tag;
    logic [RANK_W-1:0] rank;
    logic              last_result;
    logic              overflowed;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic drop;
    logic shift;
    logic place;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic greater;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/sis_in_if.sv =====
// Input request channel of the stable insertion sorter.
`timescale 1ns / 1ps
interface sis_in_if;
  logic               valid;
  logic               ready;
  sis_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sis_out_if.sv =====
// Result request channel of the stable insertion sorter.
`timescale 1ns / 1ps
interface sis_out_if;
  logic                valid;
  logic                ready;
  sis_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stable_insertion_sorter.sv =====
// An accepted entry goes after held entries with keys not greater; the scan shifts greater
// ones up, one shift per cycle. in_ready is high only in S_IDLE: no new entry is taken until
// the scan places the last one. Drain: after a last entry, S_EMIT_RD reads each result through
// the store read port and S_EMIT_LD loads it into the free output register, held until taken.
// Reset clears the controller, count, overflow flag and output valid; store data is kept.
`timescale 1ns / 1ps
module stable_insertion_sorter #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sis_in_if.sink     in_req,
  sis_out_if.source  out_req
);
  import sis_pkg::*;

  localparam int SKEY_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  sis_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_last_item (in_req.data.last_item),
    .in_ready     (in_req.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  sis_dp #(
    .ENTRIES (ENTRIES),
    .SKEY_W  (SKEY_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_req.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_req.ready),
    .out_valid (out_req.valid),
    .out_data  (out_req.data)
  );

endmodule

// ===== rtl/sis_ctrl.sv =====
// Controller state machine of the stable insertion sorter.
`timescale 1ns / 1ps
`include "stable_insertion_sorter_macros.svh"
module sis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_item,
  output logic                in_ready,
  output sis_pkg::ctrl_cmd_t  cmd,
  input  sis_pkg::dp_status_t sts
);
  import sis_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT_RD, S_EMIT_LD} state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_item;
          if (sts.full) begin
            cmd.drop  = 1'b1;
            state_nxt = in_last_item ? S_EMIT_RD : S_IDLE;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place = 1'b1;
          state_nxt = last_r ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  `SIS_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_valid && in_ready && !sts.full, state_r == S_SCAN)
  `SIS_ASSERT_NEXT(a_drop_idle, clk, rst_n,
                   in_valid && in_ready && sts.full && !in_last_item, state_r == S_IDLE)
  `SIS_ASSERT_NEXT(a_final_idle, clk, rst_n, cmd.emit_load && sts.emit_last, state_r == S_IDLE)

endmodule

// ===== rtl/sis_dp.sv =====
// Datapath of the stable insertion sorter: entry store, counters and result register.
`timescale 1ns / 1ps
`include "stable_insertion_sorter_macros.svh"
module sis_dp #(
  parameter int ENTRIES = 16,
  parameter int SKEY_W  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sis_pkg::in_item_t   in_data,
  input  sis_pkg::ctrl_cmd_t  cmd,
  output sis_pkg::dp_status_t sts,
  input  logic                out_ready,
  output logic                out_valid,
  output sis_pkg::out_item_t  out_data
);
  import sis_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = SKEY_W + TAG_W;

  logic [EW-1:0]     mem [ENTRIES];
  logic [EW-1:0]     rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [SKEY_W-1:0] rd_key;
  logic [SKEY_W-1:0] key_r;
  logic [TAG_W-1:0]  tag_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     held_r;
  logic              drop_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic [IW+RANK_W-1:0] rank_ext;

  assign rd_key   = rd_data_r[EW-1:TAG_W];
  assign rank_ext = {{RANK_W{1'b0}}, idx_r};

  assign sts.full      = (held_r == CW'(ENTRIES));
  assign sts.greater   = (pos_r != '0) && (rd_key > key_r);
  assign sts.emit_last = ((CW'(idx_r) + CW'(1)) == held_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    priority if (cmd.load_in) begin
      rd_addr = IW'(held_r - CW'(1));
    end else if (cmd.shift) begin
      rd_addr = pos_r - IW'(1) - IW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    wr_en   = cmd.shift || cmd.place;
    wr_addr = pos_r;
    wr_data = cmd.shift ? rd_data_r : {key_r, tag_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r <= in_data.time_key[SKEY_W-1:0];
      tag_r <= in_data.entry_tag;
    end
    if (cmd.emit_load) begin
      out_r.sorted_key  <= KEY_W'(rd_key);
      out_r.sorted_tag  <= rd_data_r[TAG_W-1:0];
      out_r.rank        <= rank_ext[RANK_W-1:0];
      out_r.last_result <= sts.emit_last;
      out_r.overflowed  <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      drop_r      <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        pos_r <= IW'(held_r);
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.shift) begin
        pos_r <= pos_r - IW'(1);
      end
      if (cmd.place) begin
        held_r <= held_r + CW'(1);
      end
      if (out_valid_r && out_ready && !cmd.emit_load) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
        if (sts.emit_last) begin
          held_r <= '0;
          drop_r <= 1'b0;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + IW'(1);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SIS_ASSERT_IMPLIES(a_held_bound, clk, rst_n, 1'b1, held_r <= CW'(ENTRIES))
  `SIS_ASSERT_IMPLIES(a_shift_pos, clk, rst_n, cmd.shift, pos_r != '0)
  `SIS_ASSERT_NEXT(a_run_cleared, clk, rst_n, cmd.emit_load && sts.emit_last,
                   held_r == '0 && !drop_r && idx_r == '0)

endmodule
